// ----- hdl/atsa_pkg.sv -----
// ----------------------------------------------------------------------------
// atsa_pkg
// Shared types, constants and the arctangent step table for the tilt to
// servo angle pipeline.
// ----------------------------------------------------------------------------
package atsa_pkg;

    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 8;

    // input samples carry this many fraction bits inside the cordic
    localparam int GUARD_BITS = 14;
    // fraction bits of the angle step table
    localparam int TAB_FRAC   = 16;
    localparam int TAB_LEN    = 24;

    localparam int AXIS_W     = 16;
    localparam int BASE_W     = 8;
    localparam int PITCH_W    = 16;
    localparam int SERVO_W    = 18;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;

    // x/y datapath; magnitude stays below 2^31 for any sample
    localparam int CORDIC_W   = 34;
    localparam int MAG_W      = 32;
    localparam int GAIN_W     = 30;
    localparam int PROD_W     = MAG_W + GAIN_W;
    // angle accumulator, degrees with TAB_FRAC fraction bits
    localparam int ACC_W      = 25;

    localparam logic [GAIN_W-1:0] INV_GAIN_Q30 = 30'd652032874;
    localparam int RIGHT_ANGLE = 90;
    localparam int BASE_MAX    = 180;
    localparam logic [BASE_W-1:0] BASE_RESET = 8'd90;

    // atan(2^-i) in degrees, rounded to nearest
    localparam int ATAN_DEG_Q16 [TAB_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic                     yz_zero;
        logic signed [AXIS_W-1:0] ax;
    } side_t;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [ACC_W-1:0]    acc;
        side_t                      side;
    } cordic_data_t;

endpackage

// ----- hdl/atsa_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// atsa_cordic_cell
// One vectoring micro-rotation with its own pipeline register and
// valid/ready hand-off to the next cell.
// ----------------------------------------------------------------------------
module atsa_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  atsa_pkg::cordic_data_t in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output atsa_pkg::cordic_data_t out_data
);
    import atsa_pkg::*;

    localparam logic signed [ACC_W-1:0] STEP = ACC_W'(ATAN_DEG_Q16[STAGE]);

    logic                       valid_reg;
    cordic_data_t               data_reg;
    cordic_data_t               data_next;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;

    assign dx = in_data.y >>> STAGE;
    assign dy = in_data.x >>> STAGE;

    always_comb begin
        data_next      = in_data;
        if (!in_data.y[CORDIC_W-1]) begin
            data_next.x   = in_data.x + dx;
            data_next.y   = in_data.y - dy;
            data_next.acc = in_data.acc + STEP;
        end else begin
            data_next.x   = in_data.x - dx;
            data_next.y   = in_data.y + dy;
            data_next.acc = in_data.acc - STEP;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- hdl/atsa_gain_stage.sv -----
// ----------------------------------------------------------------------------
// atsa_gain_stage
// Scales the first cordic magnitude by the inverse gain and sets up the
// second rotation on (r, -x).
// ----------------------------------------------------------------------------
module atsa_gain_stage (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  atsa_pkg::cordic_data_t in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output atsa_pkg::cordic_data_t out_data
);
    import atsa_pkg::*;

    logic                       valid_reg;
    cordic_data_t               data_reg;
    cordic_data_t               data_next;
    logic [PROD_W-1:0]          prod;
    logic [MAG_W-1:0]           r_mag;
    logic signed [CORDIC_W-1:0] ax_ext;

    // magnitude is never negative after the first rotation
    assign prod   = PROD_W'(in_data.x[MAG_W-1:0]) * PROD_W'(INV_GAIN_Q30);
    assign r_mag  = prod[GAIN_W +: MAG_W];
    assign ax_ext = CORDIC_W'(in_data.side.ax);

    always_comb begin
        data_next      = in_data;
        data_next.x    = signed'(CORDIC_W'(r_mag));
        data_next.y    = (-ax_ext) <<< GUARD_BITS;
        data_next.acc  = '0;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- hdl/atsa_out_stage.sv -----
// ----------------------------------------------------------------------------
// atsa_out_stage
// Clamps and rounds the accumulated angle, adds the base angle and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module atsa_out_stage #(
    parameter int ANGLE_FRAC_BITS = atsa_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  atsa_pkg::cordic_data_t            in_data,
    input  logic [atsa_pkg::BASE_W-1:0]       base_angle,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [atsa_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import atsa_pkg::*;

    localparam int PW = ANGLE_FRAC_BITS + 10;
    localparam int SW = ANGLE_FRAC_BITS + 11;
    localparam int SH = TAB_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ACC_LIM  = ACC_W'(RIGHT_ANGLE) <<< TAB_FRAC;
    localparam logic signed [ACC_W-1:0] HALF     = ACC_W'(1) <<< (SH - 1);
    localparam logic signed [PW-1:0]    LIM      = PW'(RIGHT_ANGLE) <<< ANGLE_FRAC_BITS;
    localparam logic [BASE_W-1:0]       BASE_TOP = BASE_W'(BASE_MAX);

    logic                      valid_reg;
    logic [OUT_DATA_W-1:0]     tdata_reg;
    logic [OUT_DATA_W-1:0]     tdata_next;
    logic signed [ACC_W-1:0]   acc_clamp;
    logic signed [ACC_W-1:0]   acc_round;
    logic signed [PW-1:0]      pitch_rnd;
    logic signed [PW-1:0]      pitch;
    logic [BASE_W-1:0]         base_sat;
    logic signed [SW-1:0]      servo;
    logic signed [PW+15:0]     pitch_wide;
    logic signed [SW+17:0]     servo_wide;

    always_comb begin
        if (in_data.acc > ACC_LIM) begin
            acc_clamp = ACC_LIM;
        end else if (in_data.acc < -ACC_LIM) begin
            acc_clamp = -ACC_LIM;
        end else begin
            acc_clamp = in_data.acc;
        end
        acc_round = (acc_clamp + HALF) >>> SH;
        pitch_rnd = PW'(acc_round);

        if (in_data.side.yz_zero) begin
            // straight up or down, or no reading at all
            if (in_data.side.ax < 0) begin
                pitch = LIM;
            end else if (in_data.side.ax > 0) begin
                pitch = -LIM;
            end else begin
                pitch = '0;
            end
        end else if (pitch_rnd > LIM) begin
            pitch = LIM;
        end else if (pitch_rnd < -LIM) begin
            pitch = -LIM;
        end else begin
            pitch = pitch_rnd;
        end

        base_sat   = (base_angle > BASE_TOP) ? BASE_TOP : base_angle;
        servo      = (signed'(SW'(base_sat)) <<< ANGLE_FRAC_BITS) + SW'(pitch);
        pitch_wide = (PW + 16)'(pitch);
        servo_wide = (SW + 18)'(servo);
        tdata_next = OUT_DATA_W'({servo_wide[SERVO_W-1:0], pitch_wide[PITCH_W-1:0]});
    end

    assign in_ready = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            tdata_reg <= tdata_next;
        end
    end

endmodule

// ----- hdl/accel_tilt_to_servo_angle_unit.sv -----
// ----------------------------------------------------------------------------
// accel_tilt_to_servo_angle_unit
// Accelerometer pitch by two chained vectoring cordics, plus servo command.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one raw x/y/z accelerometer sample per transaction.
//   m_ channel: pitch and servo angle in 1/2^ANGLE_FRAC_BITS degree.
//   cfg_wr_en/cfg_wr_data write the base angle in whole degrees; write it
//   only while no sample is in flight. Values above 180 act as 180.
// Pipeline: from input to output transaction a sample passes one cell
//   per micro-rotation in each cordic, one gain multiplier stage and
//   one output register.
// Throughput: one sample per cycle; every cell holds its own item, so a
//   new sample enters each cycle the chain is moving.
// Reset: clears all valid flags and sets the base angle to 90 degrees.
// Stall: when m_tready is low the result holds; the chain keeps filling
//   its empty cells and s_tready drops only once the cells behind the
//   output register are all occupied.
// ----------------------------------------------------------------------------
module accel_tilt_to_servo_angle_unit #(
    parameter int CORDIC_STAGES   = atsa_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_FRAC_BITS = atsa_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    input  logic [atsa_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pitch_angle [15:0], servo_angle [33:16], zero [39:34]
    output logic [atsa_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [atsa_pkg::BASE_W-1:0]       cfg_wr_data
);
    import atsa_pkg::*;

    logic [BASE_W-1:0]          base_reg;
    logic signed [AXIS_W-1:0]   ax;
    logic signed [AXIS_W-1:0]   ay;
    logic signed [AXIS_W-1:0]   az;
    logic signed [CORDIC_W-1:0] ay_ext;
    logic signed [CORDIC_W-1:0] az_ext;

    cordic_data_t d1 [CORDIC_STAGES+1];
    logic         v1 [CORDIC_STAGES+1];
    logic         r1 [CORDIC_STAGES+1];
    cordic_data_t d2 [CORDIC_STAGES+1];
    logic         v2 [CORDIC_STAGES+1];
    logic         r2 [CORDIC_STAGES+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_RESET;
        end else if (cfg_wr_en) begin
            base_reg <= cfg_wr_data;
        end
    end

    assign ax     = s_tdata[AXIS_W-1:0];
    assign ay     = s_tdata[2*AXIS_W-1:AXIS_W];
    assign az     = s_tdata[3*AXIS_W-1:2*AXIS_W];
    assign ay_ext = CORDIC_W'(ay);
    assign az_ext = CORDIC_W'(az);

    // first rotation works on (|z|, |y|) for the horizontal magnitude
    always_comb begin
        d1[0].x            = (az_ext < 0 ? -az_ext : az_ext) <<< GUARD_BITS;
        d1[0].y            = (ay_ext < 0 ? -ay_ext : ay_ext) <<< GUARD_BITS;
        d1[0].acc          = '0;
        d1[0].side.yz_zero = (ay == 0) && (az == 0);
        d1[0].side.ax      = ax;
    end
    assign v1[0]    = s_tvalid;
    assign s_tready = r1[0];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_mag
        atsa_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (v1[i]),
            .in_ready  (r1[i]),
            .in_data   (d1[i]),
            .out_valid (v1[i+1]),
            .out_ready (r1[i+1]),
            .out_data  (d1[i+1])
        );
    end

    atsa_gain_stage u_gain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1[CORDIC_STAGES]),
        .in_ready  (r1[CORDIC_STAGES]),
        .in_data   (d1[CORDIC_STAGES]),
        .out_valid (v2[0]),
        .out_ready (r2[0]),
        .out_data  (d2[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_ang
        atsa_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (v2[i]),
            .in_ready  (r2[i]),
            .in_data   (d2[i]),
            .out_valid (v2[i+1]),
            .out_ready (r2[i+1]),
            .out_data  (d2[i+1])
        );
    end

    atsa_out_stage #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (v2[CORDIC_STAGES]),
        .in_ready   (r2[CORDIC_STAGES]),
        .in_data    (d2[CORDIC_STAGES]),
        .base_angle (base_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
